// ===== src/mwto_pkg.sv =====
// Package for the multiwave table oscillator: constants, codes, payload types, sine table.
`default_nettype none

package mwto_pkg;

  // Table and phase geometry
  localparam int unsigned TABLE_BITS      = 8;
  localparam int unsigned PHASE_FRAC_BITS = 24;
  localparam int unsigned TAB_N           = 1 << TABLE_BITS;
  localparam int unsigned TAB_MASK        = TAB_N - 1;
  localparam int unsigned TAB_HALF        = TAB_N >> 1;
  localparam int unsigned TAB_QTR         = TAB_N >> 2;
  localparam int unsigned QIDX_W          = TABLE_BITS - 1;
  localparam int unsigned TRI_LO          = TAB_MASK / 4;
  localparam int unsigned TRI_HI          = 3 * TAB_MASK / 4;
  localparam int unsigned SCALE_SH        = 15 - TABLE_BITS;
  localparam int unsigned THR_W           = 9;
  localparam int unsigned CMP_W           = (TABLE_BITS > THR_W) ? TABLE_BITS : THR_W;

  // Datapath widths
  localparam int unsigned ENV_W  = 17;
  localparam int unsigned VOL_W  = 16;
  localparam int unsigned MAG_W  = 16;
  localparam int unsigned WAVE_W = 17;
  localparam int unsigned MUL_A_W = ENV_W + VOL_W;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned PCM_LSB = 31;
  localparam int unsigned PCM_W   = 18;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVEFORM  = 4'd0,
    CFG_STEP      = 4'd1,
    CFG_VOLUME    = 4'd2,
    CFG_THRESHOLD = 4'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    WAVE_SINE  = 2'd0,
    WAVE_SAW   = 2'd1,
    WAVE_TRI   = 2'd2,
    WAVE_PULSE = 2'd3
  } wave_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAVE,
    ST_MUL,
    ST_SUM
  } state_e;

  typedef struct packed {
    logic [ENV_W-1:0]   envelope_level;
    logic signed [31:0] mix_in_left;
    logic signed [31:0] mix_in_right;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] mix_out_left;
    logic signed [31:0] mix_out_right;
  } out_req_t;

  // Quarter-wave sine, 32768*sin(2*pi*q/N) for q = 0..N/4, built at elaboration
  typedef logic [MAG_W-1:0] sine_tab_t [TAB_QTR+1];

  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
  localparam logic [63:0] Q31_ONE = 64'h0000_0000_8000_0000;
  // Series divisors, innermost term first (entry 0 is the rightmost)
  localparam logic [5:0][63:0] SINE_DIVS = {64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] s;
    for (int unsigned q = 0; q <= TAB_QTR; q++) begin
      x  = ((((PI_Q62 >> 20) * 64'(q)) >> (TABLE_BITS - 1)) + 64'd1024) >> 11;
      x2 = ((x * x) + (64'd1 << 30)) >> 31;
      t  = Q31_ONE;
      for (int k = 0; k < 6; k++) begin
        d = ((x2 * t) >> 31) / SINE_DIVS[k];
        t = (d >= Q31_ONE) ? 64'd0 : (Q31_ONE - d);
      end
      s = (x * t) >> 31;
      s = (s + (64'd1 << 15)) >> 16;
      if (s > 64'd32767) begin
        s = 64'd32767;
      end
      tab[q] = MAG_W'(s);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

// ===== src/multiwave_table_oscillator_top.sv =====
// Multiwave table oscillator: phase accumulator, waveform lookup, shared multiplier, mixer.
// Requests are accepted in IDLE only; the waveform/envelope step and the wave-magnitude
// multiply then run in turn on the single shared multiplier, and the mix add follows, so a
// new request waits until the last leaves the add step, which a stalled output holds.
// Reset: asynchronous, clears phase, registers to their defaults and all valid state.
`default_nettype none

module multiwave_table_oscillator_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [mwto_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [mwto_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // Sample request channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire mwto_pkg::in_req_t                   in_data_i,
  // Mixed result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output mwto_pkg::out_req_t                       out_data_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  mwto_pkg::wave_e                     wave_q;
  logic [31:0]                         step_q;
  logic [mwto_pkg::VOL_W-1:0]          volume_q;
  logic [mwto_pkg::THR_W-1:0]          thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q   <= mwto_pkg::WAVE_SINE;
      step_q   <= '0;
      volume_q <= '0;
      thr_q    <= mwto_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      // Drop writes to indexes beyond the register list.
      unique case (cfg_index_i)
        mwto_pkg::CFG_WAVEFORM:  wave_q   <= mwto_pkg::wave_e'(cfg_wdata_i[1:0]);
        mwto_pkg::CFG_STEP:      step_q   <= cfg_wdata_i;
        mwto_pkg::CFG_VOLUME:    volume_q <= cfg_wdata_i[mwto_pkg::VOL_W-1:0];
        mwto_pkg::CFG_THRESHOLD: thr_q    <= cfg_wdata_i[mwto_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and control
  // ---------------------------------------------------------------------------
  mwto_pkg::state_e state_q, state_d;
  logic             accept;
  logic             mul_sel_wave;   // 0: envelope x volume, 1: product x wave magnitude
  logic             mul_en;
  logic             sum_load;
  logic             out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_o || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mwto_pkg::ST_IDLE: if (in_valid_i) state_d = mwto_pkg::ST_WAVE;
      mwto_pkg::ST_WAVE: state_d = mwto_pkg::ST_MUL;
      mwto_pkg::ST_MUL:  state_d = mwto_pkg::ST_SUM;
      mwto_pkg::ST_SUM:  if (out_free) state_d = mwto_pkg::ST_IDLE;
      default:           state_d = mwto_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    mul_en       = 1'b0;
    mul_sel_wave = 1'b0;
    sum_load     = 1'b0;
    unique case (state_q)
      mwto_pkg::ST_IDLE: in_ready_o = 1'b1;
      mwto_pkg::ST_WAVE: mul_en = 1'b1;
      mwto_pkg::ST_MUL: begin
        mul_en       = 1'b1;
        mul_sel_wave = 1'b1;
      end
      mwto_pkg::ST_SUM:  sum_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mwto_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Phase accumulator and request capture
  // ---------------------------------------------------------------------------
  logic [31:0]                         phase_q;
  logic [mwto_pkg::TABLE_BITS-1:0]     idx_q;
  logic [mwto_pkg::ENV_W-1:0]          env_q;
  logic signed [31:0]                  left_q;
  logic signed [31:0]                  right_q;
  logic                                vol_zero;

  assign vol_zero = (volume_q == '0);

  // The lookup uses the phase before the advance; zero volume freezes the phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (accept && !vol_zero) begin
      phase_q <= phase_q + step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q   <= mwto_pkg::TABLE_BITS'(phase_q >> mwto_pkg::PHASE_FRAC_BITS);
      env_q   <= in_data_i.envelope_level;
      left_q  <= in_data_i.mix_in_left;
      right_q <= in_data_i.mix_in_right;
    end
  end

  // ---------------------------------------------------------------------------
  // Waveform generation as sign and magnitude
  // ---------------------------------------------------------------------------
  logic [mwto_pkg::TABLE_BITS:0]        idx_ext;
  logic [mwto_pkg::QIDX_W-1:0]          qidx;
  logic                                 sine_neg;
  logic signed [mwto_pkg::WAVE_W-1:0]   saw_v;
  logic signed [mwto_pkg::WAVE_W-1:0]   tri_v;
  logic signed [mwto_pkg::WAVE_W-1:0]   lin_v;
  logic                                 wave_neg;
  logic [mwto_pkg::MAG_W-1:0]           wave_mag;
  logic                                 neg_q;
  logic [mwto_pkg::MAG_W-1:0]           mag_q;

  assign idx_ext = {1'b0, idx_q};

  // Fold the full-cycle index onto the quarter-wave table.
  always_comb begin
    priority if (idx_ext <= (mwto_pkg::TABLE_BITS+1)'(mwto_pkg::TAB_QTR)) begin
      qidx     = mwto_pkg::QIDX_W'(idx_ext);
      sine_neg = 1'b0;
    end else if (idx_ext <= (mwto_pkg::TABLE_BITS+1)'(mwto_pkg::TAB_HALF)) begin
      qidx     = mwto_pkg::QIDX_W'((mwto_pkg::TABLE_BITS+1)'(mwto_pkg::TAB_HALF) - idx_ext);
      sine_neg = 1'b0;
    end else if (idx_ext < (mwto_pkg::TABLE_BITS+1)'(mwto_pkg::TAB_HALF + mwto_pkg::TAB_QTR))
    begin
      qidx     = mwto_pkg::QIDX_W'(idx_ext - (mwto_pkg::TABLE_BITS+1)'(mwto_pkg::TAB_HALF));
      sine_neg = 1'b1;
    end else begin
      qidx     = mwto_pkg::QIDX_W'((mwto_pkg::TABLE_BITS+1)'(mwto_pkg::TAB_N) - idx_ext);
      sine_neg = 1'b1;
    end
  end

  always_comb begin
    saw_v = $signed(mwto_pkg::WAVE_W'({idx_q, 1'b0}))
          - $signed(mwto_pkg::WAVE_W'(mwto_pkg::TAB_N));
    saw_v = saw_v <<< mwto_pkg::SCALE_SH;

    priority if (idx_q > mwto_pkg::TABLE_BITS'(mwto_pkg::TRI_HI)) begin
      tri_v = $signed(mwto_pkg::WAVE_W'({idx_q, 2'b00}))
            - $signed(mwto_pkg::WAVE_W'(4 * mwto_pkg::TAB_MASK));
    end else if (idx_q > mwto_pkg::TABLE_BITS'(mwto_pkg::TRI_LO)) begin
      tri_v = $signed(mwto_pkg::WAVE_W'(2 * mwto_pkg::TAB_MASK))
            - $signed(mwto_pkg::WAVE_W'({idx_q, 2'b00}));
    end else begin
      tri_v = $signed(mwto_pkg::WAVE_W'({idx_q, 2'b00}));
    end
    tri_v = tri_v <<< mwto_pkg::SCALE_SH;
  end

  always_comb begin
    lin_v = (wave_q == mwto_pkg::WAVE_SAW) ? saw_v : tri_v;
    unique case (wave_q)
      mwto_pkg::WAVE_SINE: begin
        wave_neg = sine_neg;
        wave_mag = mwto_pkg::SINE_TAB[qidx];
      end
      mwto_pkg::WAVE_SAW, mwto_pkg::WAVE_TRI: begin
        wave_neg = lin_v[mwto_pkg::WAVE_W-1];
        wave_mag = wave_neg ? mwto_pkg::MAG_W'(-lin_v) : mwto_pkg::MAG_W'(lin_v);
      end
      mwto_pkg::WAVE_PULSE: begin
        // Positive only above the threshold; full scale either way.
        wave_neg = !(mwto_pkg::CMP_W'(idx_q) > mwto_pkg::CMP_W'(thr_q));
        wave_mag = mwto_pkg::MAG_W'(32768);
      end
      default: begin
        wave_neg = 1'b0;
        wave_mag = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mwto_pkg::ST_WAVE) begin
      neg_q <= wave_neg;
      mag_q <= wave_mag;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: envelope x volume, then that product x wave magnitude
  // ---------------------------------------------------------------------------
  logic [mwto_pkg::MUL_A_W-1:0] mul_a;
  logic [mwto_pkg::MUL_B_W-1:0] mul_b;
  logic [mwto_pkg::PROD_W-1:0]  prod_q;

  always_comb begin
    if (mul_sel_wave) begin
      mul_a = prod_q[mwto_pkg::MUL_A_W-1:0];
      mul_b = mwto_pkg::MUL_B_W'(mag_q);
    end else begin
      mul_a = mwto_pkg::MUL_A_W'(env_q);
      mul_b = mwto_pkg::MUL_B_W'(volume_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mwto_pkg::PROD_W'(mul_a) * mwto_pkg::PROD_W'(mul_b);
    end
  end

  // ---------------------------------------------------------------------------
  // Mix add and output register
  // ---------------------------------------------------------------------------
  logic [mwto_pkg::PCM_W-1:0] pcm_mag;
  logic [31:0]                pcm;
  logic                       out_valid_q;
  mwto_pkg::out_req_t         out_q;

  // Truncate toward zero: shift the magnitude, then apply the sign.
  assign pcm_mag = prod_q[mwto_pkg::PCM_LSB +: mwto_pkg::PCM_W];

  always_comb begin
    if (vol_zero) begin
      pcm = '0;
    end else if (neg_q) begin
      pcm = 32'(0) - 32'(pcm_mag);
    end else begin
      pcm = 32'(pcm_mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sum_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_load) begin
      out_q.mix_out_left  <= left_q + $signed(pcm);
      out_q.mix_out_right <= right_q + $signed(pcm);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts_wave : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == mwto_pkg::ST_WAVE)
    else $error("accepted request did not start the waveform step");

  a_zero_volume_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vol_zero |=> $stable(phase_q))
    else $error("phase advanced with zero volume");

  a_result_from_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == mwto_pkg::ST_SUM)
    else $error("result appeared outside the add step");

  a_stall_holds_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mwto_pkg::ST_SUM) && out_valid_o && !out_ready_i
      |=> state_q == mwto_pkg::ST_SUM)
    else $error("add step left while the output was stalled");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for the multiwave table oscillator: table-driven and random requests.
module tb_top;

  // Run geometry
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 190;
  localparam int unsigned DIR_ROWS     = 25;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned MAX_REPORTS  = 10;

  // Oscillator geometry, derived locally for the predictor
  localparam int          WAVE_N     = 1 << mwto_pkg::TABLE_BITS;
  localparam int          WAVE_M     = WAVE_N - 1;
  localparam int          WAVE_SCALE = 1 << (15 - mwto_pkg::TABLE_BITS);
  localparam logic [63:0] PI_FIX     = 64'hC90FDAA22168C235;
  localparam logic [63:0] ONE_FIX    = 64'h0000_0000_8000_0000;

  localparam logic [mwto_pkg::ENV_W-1:0]     ENV_UNITY = 17'h10000;
  localparam logic [mwto_pkg::ENV_W-1:0]     ENV_TOP   = 17'h1FFFF;
  // Index past the last register; a write there must be ignored
  localparam logic [mwto_pkg::CFG_IDX_W-1:0] CFG_SPARE = 4'd9;

  // Waveform codes as register write data
  localparam logic [31:0] SEL_SINE  = 32'(mwto_pkg::WAVE_SINE);
  localparam logic [31:0] SEL_TRI   = 32'(mwto_pkg::WAVE_TRI);
  localparam logic [31:0] SEL_PULSE = 32'(mwto_pkg::WAVE_PULSE);

  typedef struct packed {
    logic                            wr;
    logic [mwto_pkg::CFG_IDX_W-1:0]  wr_idx;
    logic [31:0]                     wr_val;
    logic [mwto_pkg::ENV_W-1:0]      env;
    logic [31:0]                     left;
    logic [31:0]                     right;
    logic                            fixed;
    logic [31:0]                     res_l;
    logic [31:0]                     res_r;
  } drow_t;

  // DUT connections; every input is known from time zero
  logic                            clk_i    = 1'b0;
  logic                            rst_ni   = 1'b0;
  logic                            cfg_we   = 1'b0;
  logic [mwto_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [mwto_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready_o;
  mwto_pkg::in_req_t               in_req   = '0;
  logic                            out_valid_o;
  logic                            out_ready = 1'b0;
  mwto_pkg::out_req_t              out_res;

  // Predictor state: register copies and the phase accumulator
  mwto_pkg::wave_e osc_wave   = mwto_pkg::WAVE_SINE;
  logic [31:0]     osc_step   = '0;
  logic [15:0]     osc_volume = '0;
  logic [8:0]      osc_thr    = 9'd128;
  logic [31:0]     osc_phase  = '0;

  mwto_pkg::out_req_t mix_expected_q [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  logic        steady      = 1'b0;  // no idling on either side
  logic        hold_req    = 1'b0;  // ask the sink for one long hold-off

  drow_t       dir_tab [DIR_ROWS];

  multiwave_table_oscillator_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_idx),
    .cfg_wdata_i (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_res)
  );

  initial begin
    forever begin
      #10 clk_i = ~clk_i;
    end
  end

  // Quarter-wave sine magnitude by a truncated fixed-point series, rounded and clamped
  function automatic int quarter_sine_mag(input int unsigned q);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] s;
    x  = ((((PI_FIX >> 20) * 64'(q)) / 64'(WAVE_N / 2)) + 64'd1024) >> 11;
    x2 = ((x * x) + (64'd1 << 30)) >> 31;
    t  = ONE_FIX;
    // Horner form of the sine series, innermost term first
    for (int k = 0; k < 6; k++) begin
      d = ((x2 * t) >> 31) / 64'((12 - 2 * k) * (13 - 2 * k));
      t = (d >= ONE_FIX) ? 64'd0 : (ONE_FIX - d);
    end
    s = (x * t) >> 31;
    s = (s + (64'd1 << 15)) >> 16;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return int'(s);
  endfunction

  // Waveform value in Q1.15 at table index p for the current shape
  function automatic int wave_at(input int p);
    int t;
    case (osc_wave)
      mwto_pkg::WAVE_SINE: begin
        if (p <= WAVE_N / 4) return quarter_sine_mag(p);
        if (p <= WAVE_N / 2) return quarter_sine_mag(WAVE_N / 2 - p);
        if (p < 3 * WAVE_N / 4) return -quarter_sine_mag(p - WAVE_N / 2);
        return -quarter_sine_mag(WAVE_N - p);
      end
      mwto_pkg::WAVE_SAW: return (2 * p - WAVE_N) * WAVE_SCALE;
      mwto_pkg::WAVE_TRI: begin
        t = 4 * p;
        if (p > 3 * WAVE_M / 4) begin
          t = t - 4 * WAVE_M;
        end else if (p > WAVE_M / 4) begin
          t = 2 * WAVE_M - t;
        end
        return t * WAVE_SCALE;
      end
      default: return (p > int'(osc_thr)) ? 32768 : -32768;
    endcase
  endfunction

  // Mix one oscillator sample into a request and advance the phase unless the volume is zero
  function automatic mwto_pkg::out_req_t advance_oscillator(input mwto_pkg::in_req_t smp);
    mwto_pkg::out_req_t res;
    int                 w;
    logic [63:0]        mag_w;
    logic [63:0]        mag;
    logic [31:0]        pcm;
    pcm = '0;
    if (osc_volume != '0) begin
      w     = wave_at(int'(osc_phase[mwto_pkg::PHASE_FRAC_BITS +: mwto_pkg::TABLE_BITS]));
      mag_w = (w < 0) ? 64'(-w) : 64'(w);
      mag   = (64'(osc_volume) * 64'(smp.envelope_level) * mag_w) >> 31;
      pcm   = (w < 0) ? (32'd0 - mag[31:0]) : mag[31:0];
      osc_phase = osc_phase + osc_step;
    end
    res.mix_out_left  = smp.mix_in_left + pcm;
    res.mix_out_right = smp.mix_in_right + pcm;
    return res;
  endfunction

  // Drive one register write and mirror it; the caller drops the enable after a batch
  task automatic cfg_write(input logic [mwto_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      mwto_pkg::CFG_WAVEFORM:  osc_wave   = mwto_pkg::wave_e'(val[1:0]);
      mwto_pkg::CFG_STEP:      osc_step   = val;
      mwto_pkg::CFG_VOLUME:    osc_volume = val[15:0];
      mwto_pkg::CFG_THRESHOLD: osc_thr    = val[8:0];
      default: ;
    endcase
  endtask

  // Offer one request, with random idle gaps, and record what it must produce
  task automatic offer_sample(input mwto_pkg::in_req_t smp, input logic typed,
                              input mwto_pkg::out_req_t typed_res);
    mwto_pkg::out_req_t want;
    while (!steady && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    // Accepted at this edge: the predictor always runs so the phase stays in step
    want = advance_oscillator(smp);
    mix_expected_q.push_back(typed ? typed_res : want);
  endtask

  // Drop valid and wait until every recorded result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (mix_expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("tb_top: %s mismatch, expected %h got %h", what, want, got);
    end
  endtask

  // Result sink: check each accepted result, stall at random or on request
  initial begin : result_sink
    mwto_pkg::out_req_t got;
    mwto_pkg::out_req_t want;
    int unsigned        hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready) begin
        got = out_res;
        if (mix_expected_q.size() == 0) begin
          note_mismatch("unrequested result", '0, got.mix_out_left);
        end else begin
          want = mix_expected_q.pop_front();
          if (got.mix_out_left !== want.mix_out_left) begin
            note_mismatch("mix_out_left", want.mix_out_left, got.mix_out_left);
          end
          if (got.mix_out_right !== want.mix_out_right) begin
            note_mismatch("mix_out_right", want.mix_out_right, got.mix_out_right);
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      // Hold ready low for the whole hold-off, else drop it at random about ten percent of the time unless steady
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 10);
      end
    end
  end

  // Watchdog: a run that outlives the limit is a failure
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    mwto_pkg::in_req_t  smp;
    mwto_pkg::out_req_t typed_res;
    logic [31:0]        junk;
    logic [31:0]        step_pick;
    logic [15:0]        vol_pick;
    logic [8:0]         thr_pick;

    // Directed rows: optional register write (block idle), then one request.
    // Rows flagged fixed carry a result read straight off the spec; the rest use the predictor.
    dir_tab = '{
      // after reset volume is zero: pass through
      '{1'b0, mwto_pkg::CFG_WAVEFORM,  32'h0,        ENV_UNITY, 32'h7FFFFFFF, 32'h80000000,
        1'b1, 32'h7FFFFFFF, 32'h80000000},
      '{1'b0, mwto_pkg::CFG_WAVEFORM,  32'h0,        ENV_TOP,   32'h00000000, 32'hFFFFFFFF,
        1'b1, 32'h00000000, 32'hFFFFFFFF},
      // volume with junk above bit 15; sine at index zero adds nothing
      '{1'b1, mwto_pkg::CFG_VOLUME,    32'hFFFF7FFF, ENV_UNITY, 32'h00000064, 32'hFFFFFF9C,
        1'b1, 32'h00000064, 32'hFFFFFF9C},
      // saw through junk upper bits; bottom of the saw at unity envelope
      '{1'b1, mwto_pkg::CFG_WAVEFORM,  32'hFFFFFFFD, ENV_UNITY, 32'h00000000, 32'h00007FFF,
        1'b1, 32'hFFFF8001, 32'h00000000},
      // full volume, envelope above one, sum wraps
      '{1'b1, mwto_pkg::CFG_VOLUME,    32'h0000FFFF, ENV_TOP,   32'h80000000, 32'h00000000,
        1'b1, 32'h7FFE0003, 32'hFFFE0003},
      // write past the register list changes nothing
      '{1'b1, CFG_SPARE,               32'h12345678, ENV_UNITY, 32'h00000000, 32'h00000000,
        1'b1, 32'hFFFF0001, 32'hFFFF0001},
      // zero envelope adds nothing
      '{1'b0, mwto_pkg::CFG_WAVEFORM,  32'h0,        17'h0,     32'h00000005, 32'h00000006,
        1'b1, 32'h00000005, 32'h00000006},
      // one table position per sample; value is taken before the advance
      '{1'b1, mwto_pkg::CFG_STEP,      32'h01000000, ENV_UNITY, 32'h00000000, 32'h00000000,
        1'b1, 32'hFFFF0001, 32'hFFFF0001},
      '{1'b0, mwto_pkg::CFG_WAVEFORM,  32'h0,        ENV_UNITY, 32'h00001000, 32'hFFFFF000,
        1'b0, 32'h0, 32'h0},
      '{1'b1, mwto_pkg::CFG_WAVEFORM,  SEL_TRI,      ENV_UNITY, 32'h00ABCDEF, 32'h00000000,
        1'b0, 32'h0, 32'h0},
      '{1'b1, mwto_pkg::CFG_STEP,      32'h40000000, ENV_UNITY, 32'h00000000, 32'h00000000,
        1'b0, 32'h0, 32'h0},
      '{1'b0, mwto_pkg::CFG_WAVEFORM,  32'h0,        ENV_TOP,   32'h7FFFFFFF, 32'h80000000,
        1'b0, 32'h0, 32'h0},
      '{1'b0, mwto_pkg::CFG_WAVEFORM,  32'h0,        17'h08000, 32'h11111111, 32'h22222222,
        1'b0, 32'h0, 32'h0},
      '{1'b1, mwto_pkg::CFG_WAVEFORM,  SEL_PULSE,    ENV_UNITY, 32'h00000000, 32'h00000000,
        1'b0, 32'h0, 32'h0},
      // threshold at the last index (junk above bit 8): pulse always negative
      '{1'b1, mwto_pkg::CFG_THRESHOLD, 32'hFFFFFEFF, ENV_UNITY, 32'h00000000, 32'h00000000,
        1'b1, 32'hFFFF0001, 32'hFFFF0001},
      '{1'b1, mwto_pkg::CFG_THRESHOLD, 32'h000001FF, ENV_UNITY, 32'h00000000, 32'h00000000,
        1'b1, 32'hFFFF0001, 32'hFFFF0001},
      '{1'b1, mwto_pkg::CFG_THRESHOLD, 32'h00000000, ENV_UNITY, 32'h00000000, 32'h00000000,
        1'b0, 32'h0, 32'h0},
      '{1'b1, mwto_pkg::CFG_THRESHOLD, 32'h00000100, ENV_UNITY, 32'h00000000, 32'h00000000,
        1'b1, 32'hFFFF0001, 32'hFFFF0001},
      '{1'b1, mwto_pkg::CFG_WAVEFORM,  SEL_SINE,     ENV_UNITY, 32'h00000000, 32'h00000000,
        1'b0, 32'h0, 32'h0},
      '{1'b1, mwto_pkg::CFG_STEP,      32'hFFFFFFFF, ENV_TOP,   32'h00000000, 32'h00000000,
        1'b0, 32'h0, 32'h0},
      '{1'b0, mwto_pkg::CFG_WAVEFORM,  32'h0,        ENV_UNITY, 32'h80000000, 32'h7FFFFFFF,
        1'b0, 32'h0, 32'h0},
      '{1'b1, mwto_pkg::CFG_STEP,      32'h80000000, ENV_UNITY, 32'h00000000, 32'h00000000,
        1'b0, 32'h0, 32'h0},
      // zero volume freezes the phase and passes the mix through
      '{1'b1, mwto_pkg::CFG_VOLUME,    32'h00000000, ENV_UNITY, 32'h00000001, 32'h00000002,
        1'b1, 32'h00000001, 32'h00000002},
      '{1'b0, mwto_pkg::CFG_WAVEFORM,  32'h0,        ENV_TOP,   32'h7FFFFFFF, 32'h80000000,
        1'b1, 32'h7FFFFFFF, 32'h80000000},
      '{1'b1, mwto_pkg::CFG_VOLUME,    32'h00000001, ENV_TOP,   32'h00000000, 32'h00000000,
        1'b0, 32'h0, 32'h0}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr) begin
        drain_results();
        cfg_write(dir_tab[i].wr_idx, dir_tab[i].wr_val);
        cfg_we <= 1'b0;
      end
      smp.envelope_level = dir_tab[i].env;
      smp.mix_in_left    = dir_tab[i].left;
      smp.mix_in_right   = dir_tab[i].right;
      typed_res.mix_out_left  = dir_tab[i].res_l;
      typed_res.mix_out_right = dir_tab[i].res_r;
      offer_sample(smp, dir_tab[i].fixed, typed_res);
    end

    // Random phases: new settings each time, written only with nothing in flight
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      drain_results();
      steady = (ph == 0);

      if (ph == 4) begin
        step_pick = '0;
      end else if (ph == 5) begin
        step_pick = 32'hFFFFFFFF;
      end else if (ph == 7) begin
        step_pick = 32'($urandom_range(32'h00FFFFFF));
      end else begin
        step_pick = $urandom;
      end
      if (ph == 6) begin
        vol_pick = '0;
      end else if (ph == 2) begin
        vol_pick = 16'hFFFF;
      end else begin
        vol_pick = 16'($urandom_range(65535, 1));
      end
      if (ph == 1) begin
        thr_pick = '0;
      end else if (ph == 3) begin
        thr_pick = 9'($urandom_range(256));
      end else if (ph == 7) begin
        thr_pick = 9'h1FF;
      end else begin
        thr_pick = 9'($urandom_range(511));
      end

      // Fill the unused upper bits with junk; the block must ignore them
      junk = $urandom;
      cfg_write(mwto_pkg::CFG_WAVEFORM, {junk[31:2], 2'(ph % 4)});
      cfg_write(mwto_pkg::CFG_STEP, step_pick);
      junk = $urandom;
      cfg_write(mwto_pkg::CFG_VOLUME, {junk[31:16], vol_pick});
      junk = $urandom;
      cfg_write(mwto_pkg::CFG_THRESHOLD, {junk[31:9], thr_pick});
      if (ph % 2 == 1) begin
        cfg_write(CFG_SPARE, $urandom);
      end
      cfg_we <= 1'b0;

      // Long sink hold-off while requests keep coming, so the input stalls
      if (ph == 1) begin
        hold_req = 1'b1;
      end

      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        // Pause the source until the block has emptied
        if (ph == 2 && k == PHASE_ITEMS / 2) begin
          drain_results();
        end
        case ($urandom_range(9))
          0:       smp.envelope_level = '0;
          1:       smp.envelope_level = ENV_UNITY;
          2:       smp.envelope_level = ENV_TOP;
          default: smp.envelope_level = 17'($urandom_range(131071));
        endcase
        smp.mix_in_left  = ($urandom_range(15) == 0) ? 32'h7FFFFFFF : $urandom;
        smp.mix_in_right = ($urandom_range(15) == 0) ? 32'h80000000 : $urandom;
        offer_sample(smp, 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
